FILE: sv/dpe_pkg.sv
// Package: shared constants, types and helpers of the damped pendulum Euler core
`default_nettype none
package dpe_pkg;

  localparam int FRAC_BITS        = 28;
  localparam int MAX_TICKS        = 15;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam logic [63:0] PI_Q61          = 64'h6487_ED51_10B4_611A;
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  typedef enum logic [1:0] {
    REG_STEP_SIZE,
    REG_DAMPING,
    REG_SINE_GAIN,
    REG_STEPS_PER_TICK
  } cfg_reg_t;

  localparam logic [15:0] STEP_SIZE_RST      = 16'd393;
  localparam logic [15:0] DAMPING_RST        = 16'd21627;
  localparam logic [15:0] SINE_GAIN_RST      = 16'd16384;
  localparam logic [3:0]  STEPS_PER_TICK_RST = 4'd10;

  localparam logic [63:0] PI_HALF_FRAC = PI_Q61 >> (62 - FRAC_BITS);
  localparam logic [31:0] THETA_RST    = (PI_HALF_FRAC > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                       : PI_HALF_FRAC[31:0];

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi_lim;
    logic signed [33:0] lo_lim;
    hi_lim = 34'sd2147483647;
    lo_lim = -34'sd2147483648;
    if (v > hi_lim) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/dpe_sine_rom.sv
// Quarter-wave sine table, Q30 entries, registered read port
`default_nettype none
module dpe_sine_rom
  import dpe_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(SINE_ENTRIES + 1)
) (
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic signed [31:0]    rd_data
);

  logic signed [31:0] rom_w [SINE_ENTRIES+1];
  logic signed [31:0] rd_data_r;

  // round(sin(k*pi/(2*N)) * 2^30), Taylor series in Q62
  function automatic logic signed [31:0] rom_entry(input int k);
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  kk;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  s;
    logic [127:0] p;
    int           i;
    q    = PI_Q61 / 64'(SINE_ENTRIES);
    r    = PI_Q61 % 64'(SINE_ENTRIES);
    kk   = 64'(k);
    x    = q * kk + (r * kk) / 64'(SINE_ENTRIES);
    p    = 128'(x) * 128'(x);
    x2   = p[125:62];
    term = x;
    s    = x;
    for (i = 1; i <= 11; i++) begin
      p    = 128'(term) * 128'(x2);
      term = p[125:62] / 64'((2 * i) * (2 * i + 1));
      if (i[0]) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    s = s + 64'h8000_0000;
    return s[63:32];
  endfunction

  for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
    assign rom_w[k] = rom_entry(k);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom_w[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: sv/dpe_mul_unit.sv
// Shared signed 33x33 multiplier with registered product
`default_nettype none
module dpe_mul_unit
  import dpe_pkg::*;
(
  input  wire logic               clk,
  input  wire mul_req_t           req,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

FILE: sv/damped_pendulum_euler_core.sv
// Damped pendulum Euler core: each request carries a tick count; the core runs
// ticks*steps_per_tick explicit Euler steps on theta/omega (Q3.28) and returns
// floor(theta*512/pi) clamped to +-256 plus the wrapping step count. One shared
// 33x33 multiplier and a quarter-wave sine ROM with a single registered read
// port carry every step through the states QUAD, RD0, RD1, SUB, DIFF, INTERP,
// GAIN, SUM, AUX and OM. The input stalls from acceptance until the result is
// posted from ST_FIN; a finished result sits in the output register and the
// next request is taken while it waits. Configuration writes are taken only
// while the core is idle.
`default_nettype none
module damped_pendulum_euler_core
  import dpe_pkg::*;
#(
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_ticks,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [9:0] out_angle,
  output logic [31:0]      out_elapsed_steps,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int IDX_W   = $clog2(SINE_ENTRIES + 1);
  localparam int POS_W   = 40 + IDX_W;
  localparam int PH_LSB  = FRAC_BITS - 8;
  localparam int SIN_SH  = 44 - FRAC_BITS;
  localparam int ANG_LSB = FRAC_BITS + 24;
  localparam int TICK_CAP = (MAX_TICKS < 15) ? MAX_TICKS : 15;
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(SINE_ENTRIES) << 40;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH,
    ST_QUAD,
    ST_RD0,
    ST_RD1,
    ST_SUB,
    ST_DIFF,
    ST_INTERP,
    ST_GAIN,
    ST_SUM,
    ST_AUX,
    ST_OM,
    ST_FIN
  } state_t;

  state_t state_r;

  logic [15:0]        step_size_r;
  logic [15:0]        damping_r;
  logic [15:0]        sine_gain_r;
  logic [3:0]         spt_r;
  logic signed [31:0] theta_r;
  logic signed [31:0] omega_r;
  logic [31:0]        count_r;
  logic [7:0]         rem_r;
  logic [IDX_W-1:0]   idx_r;
  logic [15:0]        w_r;
  logic [1:0]         quad_r;
  logic signed [31:0] bom_r;
  logic signed [31:0] lo_r;
  logic signed [32:0] diff_r;
  logic signed [31:0] sin_r;
  logic signed [32:0] sum_r;
  logic               out_valid_r;
  logic signed [9:0]  out_angle_r;
  logic [31:0]        out_steps_r;

  logic [3:0]               ticks_c;
  logic [7:0]               n_steps;
  logic                     out_free;
  logic signed [PROD_W-1:0] prod;
  mul_req_t                 mul_req;
  logic [IDX_W-1:0]         idx_hi;
  logic [IDX_W-1:0]         rom_addr;
  logic signed [31:0]       rom_q;
  logic [1:0]               quad;
  logic [39:0]              frac40;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_m;
  logic signed [31:0]       p16;
  logic signed [32:0]       p16w;
  logic signed [31:0]       asin;
  logic signed [33:0]       v_int;
  logic signed [33:0]       v_sgn;
  logic signed [31:0]       theta_new;
  logic signed [31:0]       omega_new;
  logic signed [11:0]       ang_raw;
  logic signed [9:0]        ang_sat;

  dpe_mul_unit u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  dpe_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign ticks_c = (int'(in_ticks) > TICK_CAP) ? 4'(TICK_CAP) : in_ticks;
  assign n_steps = 8'(ticks_c) * 8'(spt_r);

  // phase in quarter turns: bits above 2^40 are the quadrant
  assign quad   = prod[PH_LSB+41:PH_LSB+40];
  assign frac40 = prod[PH_LSB+39:PH_LSB];
  assign pos    = POS_W'(frac40) * POS_W'(SINE_ENTRIES);
  assign pos_m  = quad[0] ? (POS_FULL - pos) : pos;

  assign idx_hi   = (idx_r == IDX_LAST) ? idx_r : idx_r + 1'b1;
  assign rom_addr = (state_r == ST_RD1) ? idx_hi : idx_r;

  assign p16     = prod[47:16];
  assign p16w    = prod[48:16];
  assign asin    = prod[SIN_SH+31:SIN_SH];
  assign ang_raw = prod[ANG_LSB+11:ANG_LSB];

  assign v_int     = 34'(lo_r) + 34'(p16w);
  assign v_sgn     = quad_r[1] ? -v_int : v_int;
  assign theta_new = sat32(34'(theta_r) + 34'(p16));
  assign omega_new = sat32(34'(omega_r) - 34'(p16w));

  always_comb begin
    if (ang_raw > 12'sd256) begin
      ang_sat = 10'sd256;
    end else if (ang_raw < -12'sd256) begin
      ang_sat = -10'sd256;
    end else begin
      ang_sat = ang_raw[9:0];
    end
  end

  always_comb begin
    mul_req = '0;
    case (state_r)
      ST_PH, ST_OM: begin
        mul_req.en = 1'b1;
        mul_req.a  = 33'(theta_r);
        mul_req.b  = {1'b0, TWO_OVER_PI_Q32};
      end
      ST_QUAD: begin
        mul_req.en = 1'b1;
        mul_req.a  = 33'(omega_r);
        mul_req.b  = {17'd0, damping_r};
      end
      ST_RD0: begin
        mul_req.en = 1'b1;
        mul_req.a  = 33'(omega_r);
        mul_req.b  = {17'd0, step_size_r};
      end
      ST_DIFF: begin
        mul_req.en = 1'b1;
        mul_req.a  = diff_r;
        mul_req.b  = {17'd0, w_r};
      end
      ST_GAIN: begin
        mul_req.en = 1'b1;
        mul_req.a  = 33'(sin_r);
        mul_req.b  = {17'd0, sine_gain_r};
      end
      ST_AUX: begin
        mul_req.en = 1'b1;
        mul_req.a  = sum_r;
        mul_req.b  = {17'd0, step_size_r};
      end
      default: mul_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_size_r <= STEP_SIZE_RST;
      damping_r   <= DAMPING_RST;
      sine_gain_r <= SINE_GAIN_RST;
      spt_r       <= STEPS_PER_TICK_RST;
      theta_r     <= THETA_RST;
      omega_r     <= '0;
      count_r     <= '0;
      rem_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SIZE:      step_size_r <= cfg_wdata;
          REG_DAMPING:        damping_r   <= cfg_wdata;
          REG_SINE_GAIN:      sine_gain_r <= cfg_wdata;
          REG_STEPS_PER_TICK: spt_r       <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            rem_r   <= n_steps;
            count_r <= count_r + 32'(n_steps);
            state_r <= ST_PH;
          end
        end
        ST_PH: state_r <= (rem_r == '0) ? ST_FIN : ST_QUAD;
        ST_QUAD: begin
          idx_r   <= pos_m[POS_W-1:40];
          w_r     <= pos_m[39:24];
          quad_r  <= quad;
          state_r <= ST_RD0;
        end
        ST_RD0: begin
          bom_r   <= p16;
          state_r <= ST_RD1;
        end
        ST_RD1: begin
          lo_r    <= rom_q;
          theta_r <= theta_new;
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          diff_r  <= 33'(rom_q) - 33'(lo_r);
          state_r <= ST_DIFF;
        end
        ST_DIFF: state_r <= ST_INTERP;
        ST_INTERP: begin
          sin_r   <= v_sgn[31:0];
          state_r <= ST_GAIN;
        end
        ST_GAIN: state_r <= ST_SUM;
        ST_SUM: begin
          sum_r   <= 33'(bom_r) + 33'(asin);
          state_r <= ST_AUX;
        end
        ST_AUX: state_r <= ST_OM;
        ST_OM: begin
          omega_r <= omega_new;
          rem_r   <= rem_r - 1'b1;
          state_r <= (rem_r == 8'd1) ? ST_FIN : ST_QUAD;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_angle_r <= ang_sat;
            out_steps_r <= count_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_angle         = out_angle_r;
  assign out_elapsed_steps = out_steps_r;

endmodule
`default_nettype wire

FILE: sv/dpe_checker.sv
// Port-level checker for the damped pendulum Euler core, with its bind
`default_nettype none
module dpe_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [9:0] out_angle,
  input wire logic [31:0]       out_elapsed_steps,
  input wire logic              cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle) && $stable(out_elapsed_steps))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !in_stall)
    else $error("config port open while busy");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle <= 10'sd256) && (out_angle >= -10'sd256))
    else $error("angle outside clamp range");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result posted while still busy");

endmodule

bind damped_pendulum_euler_core dpe_checker u_dpe_checker (.*);
`default_nettype wire

FILE: bench/damped_pendulum_euler_core_test.sv
// Self-checking bench for the damped pendulum Euler core: directed plan, then random phases.
`timescale 1ns / 100ps

module damped_pendulum_euler_core_test;
  import dpe_pkg::*;

  localparam int ROM_N = SINE_ENTRIES_DEF;
  localparam int MISMATCH_SHOWN = 10;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 73;
  localparam longint INV_HALF_PI = longint'({32'd0, TWO_OVER_PI_Q32});
  localparam longint SAT_HI = 64'sh7FFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic signed [9:0] angle;
    logic [31:0]       steps;
  } pendulum_report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [3:0]        ticks;
    logic [15:0]       h;
    logic [15:0]       damp;
    logic [15:0]       gain;
    logic [3:0]        spt;
    logic              typed;
    logic signed [9:0] angle;
    logic [31:0]       steps;
  } plan_row_t;

  localparam int PLAN_N = 23;
  // zero step size or zero rate with no sine term keeps theta at pi/2
  localparam plan_row_t PLAN [0:PLAN_N-1] = '{
    '{ROW_ITEM, 4'd0,  16'd0, 16'd0, 16'd0, 4'd0, 1'b1, 10'sd255, 32'd0},
    '{ROW_CFG,  4'd0,  16'd0, DAMPING_RST, SINE_GAIN_RST, STEPS_PER_TICK_RST,
      1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd15, 16'd0, 16'd0, 16'd0, 4'd0, 1'b1, 10'sd255, 32'd150},
    '{ROW_CFG,  4'd0,  16'd0, 16'hFFFF, 16'hFFFF, 4'd15, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd15, 16'd0, 16'd0, 16'd0, 4'd0, 1'b1, 10'sd255, 32'd375},
    '{ROW_CFG,  4'd0,  16'd0, 16'hFFFF, 16'hFFFF, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd15, 16'd0, 16'd0, 16'd0, 4'd0, 1'b1, 10'sd255, 32'd375},
    '{ROW_CFG,  4'd0,  16'hFFFF, 16'd0, 16'd0, 4'd1, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd15, 16'd0, 16'd0, 16'd0, 4'd0, 1'b1, 10'sd255, 32'd390},
    '{ROW_ITEM, 4'd0,  16'd0, 16'd0, 16'd0, 4'd0, 1'b1, 10'sd255, 32'd390},
    '{ROW_CFG,  4'd0,  STEP_SIZE_RST, DAMPING_RST, SINE_GAIN_RST, STEPS_PER_TICK_RST,
      1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd1,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd2,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd4,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd8,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd15, 16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd3,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd0,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd7,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd5,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd10, 16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd6,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0},
    '{ROW_ITEM, 4'd1,  16'd0, 16'd0, 16'd0, 4'd0, 1'b0, 10'sd0, 32'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_ticks = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [9:0] out_angle;
  logic [31:0] out_elapsed_steps;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;

  // predictor state and register shadow
  int          sine_tab [0:ROM_N];
  int          theta_q;
  int          omega_q;
  int unsigned step_total;
  logic [15:0] h_reg;
  logic [15:0] damp_reg;
  logic [15:0] gain_reg;
  logic [3:0]  spt_reg;

  pendulum_report_t pending_reports [$];
  int gap_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int reports_checked = 0;
  int items_sent = 0;
  int settings_used = 0;

  damped_pendulum_euler_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ticks          (in_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_angle         (out_angle),
    .out_elapsed_steps (out_elapsed_steps),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit [63:0] mul_q62(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic int clamp32(input longint v);
    if (v > SAT_HI) return int'(SAT_HI);
    if (v < SAT_LO) return int'(SAT_LO);
    return int'(v);
  endfunction

  function automatic pendulum_report_t advance_pendulum(input logic [3:0] ticks);
    longint th, om, ph, v, w, a_sin, b_om, aux, hh, a;
    bit [63:0] u, pos, idx;
    int unsigned n;
    pendulum_report_t rpt;
    n = ticks * spt_reg;
    step_total += n;
    hh = longint'({48'd0, h_reg});
    for (int unsigned i = 0; i < n; i++) begin
      th = theta_q;
      om = omega_q;
      // sine lookup: theta to quarter turns, mirror/negate, interpolate
      ph = (th * INV_HALF_PI) >>> (FRAC_BITS - 8);
      u = ph;
      pos = {24'd0, u[39:0]} * ROM_N;
      if (u[40]) pos = (64'(ROM_N) << 40) - pos;
      idx = pos >> 40;
      w = longint'({48'd0, pos[39:24]});
      if (idx >= ROM_N) begin
        v = sine_tab[ROM_N];
      end else begin
        v = sine_tab[idx];
        v = v + (((longint'(sine_tab[idx + 1]) - v) * w) >>> 16);
      end
      if (u[41]) v = -v;
      a_sin = (v * longint'({48'd0, gain_reg})) >>> 16;
      b_om = (om * longint'({48'd0, damp_reg})) >>> 16;
      aux = (hh * (b_om + a_sin)) >>> 16;
      theta_q = clamp32(th + ((hh * om) >>> 16));
      omega_q = clamp32(om - aux);
    end
    a = (longint'(theta_q) * INV_HALF_PI) >>> (FRAC_BITS + 24);
    if (a > 256) a = 256;
    if (a < -256) a = -256;
    rpt.angle = a[9:0];
    rpt.steps = step_total;
    return rpt;
  endfunction

  task automatic send_ticks(input logic [3:0] t, input logic typed,
                            input pendulum_report_t typed_rpt);
    pendulum_report_t rpt;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ticks <= t;
    do @(posedge clk); while (in_stall);
    rpt = advance_pendulum(t);
    pending_reports.push_back(typed ? typed_rpt : rpt);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP_SIZE:      h_reg = data;
      REG_DAMPING:        damp_reg = data;
      REG_SINE_GAIN:      gain_reg = data;
      REG_STEPS_PER_TICK: spt_reg = data[3:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] h, input logic [15:0] damp,
                              input logic [15:0] gain, input logic [3:0] spt);
    logic [11:0] junk;
    junk = 12'($urandom_range(4095));
    write_reg(REG_STEP_SIZE, h);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_SINE_GAIN, gain);
    // upper bits of the tick-rate write are don't-care
    write_reg(REG_STEPS_PER_TICK, {junk, spt});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    pendulum_report_t want;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("unexpected report: angle %0d steps %0d", out_angle, out_elapsed_steps);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_angle !== want.angle || out_elapsed_steps !== want.steps) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN)
            $display("report %0d: angle exp %0d got %0d, steps exp %0d got %0d",
                     reports_checked, want.angle, out_angle, want.steps,
                     out_elapsed_steps);
        end
      end
    end
  end

  initial begin
    bit [63:0] q, r, x, x2, term, s;
    logic [3:0] t;
    int n;
    int leftover;

    // quarter-wave sine table, Q30, from a truncated Taylor series
    q = PI_Q61 / ROM_N;
    r = PI_Q61 % ROM_N;
    for (int k = 0; k <= ROM_N; k++) begin
      x = q * k + (r * k) / ROM_N;
      x2 = mul_q62(x, x);
      term = x;
      s = x;
      for (int i = 1; i <= 11; i++) begin
        term = mul_q62(term, x2) / (64'(2 * i) * 64'(2 * i + 1));
        s = i[0] ? s - term : s + term;
      end
      sine_tab[k] = int'((s + 64'h8000_0000) >> 32);
    end

    theta_q = clamp32(longint'(PI_Q61 >> (62 - FRAC_BITS)));
    omega_q = 0;
    step_total = 0;
    h_reg = STEP_SIZE_RST;
    damp_reg = DAMPING_RST;
    gain_reg = SINE_GAIN_RST;
    spt_reg = STEPS_PER_TICK_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_N; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain_reports();
        program_regs(PLAN[i].h, PLAN[i].damp, PLAN[i].gain, PLAN[i].spt);
      end else begin
        send_ticks(PLAN[i].ticks, PLAN[i].typed, {PLAN[i].angle, PLAN[i].steps});
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_reports();
      case (phase)
        0: program_regs(STEP_SIZE_RST, DAMPING_RST, SINE_GAIN_RST, STEPS_PER_TICK_RST);
        1: program_regs(16'hFFFF, 16'($urandom), 16'hFFFF, 4'd15);
        2: program_regs(16'($urandom_range(4000)), 16'($urandom), 16'($urandom), 4'd0);
        3: program_regs(STEP_SIZE_RST, 16'd0, SINE_GAIN_RST, 4'd15);
        4: program_regs(16'hFFFF, 16'hFFFF, 16'd0, 4'd1);
        default: program_regs(16'($urandom_range(4000)), 16'($urandom), 16'($urandom),
                              4'($urandom_range(1, 15)));
      endcase
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly short updates, some up to the full tick range
        t = ($urandom_range(4) != 0) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
        send_ticks(t, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    for (n = 0; n < 30000 && pending_reports.size() != 0; n++) @(posedge clk);
    repeat (50) @(posedge clk);
    leftover = pending_reports.size();
    $display("%0d tick requests under %0d register settings, %0d reports compared",
             items_sent, settings_used, reports_checked);
    $display("%0d mismatches, %0d reports never returned", mismatches, leftover);
    if (mismatches == 0 && leftover == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd60_000_000);
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/dpe_pkg.sv
sv/dpe_sine_rom.sv
sv/dpe_mul_unit.sv
sv/damped_pendulum_euler_core.sv
sv/dpe_checker.sv
bench/damped_pendulum_euler_core_test.sv
